// File: design/arl_pkg.sv
// Shared types and codes for the ADC code to resistance linearizer.
package arl_pkg;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int PTS_W      = 5;
	localparam int LIMIT_W    = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b1;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_CONVERT = 1'b1;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_SCAN   = 9'b000000010,
		ST_FETCH0 = 9'b000000100,
		ST_FETCH1 = 9'b000001000,
		ST_FETCH2 = 9'b000010000,
		ST_MUL    = 9'b000100000,
		ST_NORM   = 9'b001000000,
		ST_DIV    = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

endpackage

// File: design/arl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module arl_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/adc_to_resistance_linearizer.sv
// A load item is written to the table when it is taken; a convert item's result is produced by a table
// scan of one RAM read per point, a shift-add multiply of one code bit per cycle and a restoring
// divide of one quotient bit per cycle.
// A new item is taken the cycle after the result enters the output register.
// Zero-width segments, unmatched codes and negative or saturating results finish early.
// Reset clears control state and valid flags, points to 2, limit to 0; the table is not cleared.
module adc_to_resistance_linearizer #(
	parameter int MAX_POINTS = 16,
	parameter int CODE_BITS  = 16,
	parameter int OHMS_BITS  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [arl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [arl_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [$clog2(MAX_POINTS)-1:0]     point_index,
	input  logic [CODE_BITS-1:0]              point_code,
	input  logic [OHMS_BITS-1:0]              point_ohms,
	input  logic [CODE_BITS-1:0]              sample_code,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [OHMS_BITS-1:0]              ohms,
	output logic                              below_limit,
	output logic                              segment_error
);

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int NW     = (CNT_W > arl_pkg::PTS_W) ? CNT_W : arl_pkg::PTS_W;
	localparam int RAM_W  = CODE_BITS + OHMS_BITS;
	localparam int NUM_W  = OHMS_BITS + CODE_BITS + 2;
	localparam int CW     = $clog2(CODE_BITS + OHMS_BITS);
	localparam int CMP_W  = (OHMS_BITS > arl_pkg::LIMIT_W) ? OHMS_BITS : arl_pkg::LIMIT_W;

	arl_pkg::state_t state_q, state_next;

	logic [arl_pkg::PTS_W-1:0]   points_q;
	logic [arl_pkg::LIMIT_W-1:0] limit_q;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_raddr;
	logic [RAM_W-1:0]     ram_rdata;
	logic [CODE_BITS-1:0] code_rd;
	logic [OHMS_BITS-1:0] ohms_rd;

	logic                 in_xfer, conv_xfer, out_free;
	logic [NW-1:0]        pts_ext;
	logic [CNT_W-1:0]     n_clamp;

	logic [CODE_BITS-1:0] u_q, first_q, prev_q, c0_q;
	logic [CNT_W-1:0]     n_q, addr_q;
	logic                 found_q;
	logic [IDX_W-1:0]     seg_q;
	logic                 rvalid_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 issue, hit, last_rd, found_any;
	logic [IDX_W-1:0]     seg_any;

	logic [OHMS_BITS-1:0] r0_q, r1_q;
	logic [CODE_BITS:0]   a_q, b_q;
	logic                 den_neg_q;
	logic [CODE_BITS-1:0] den_mag_q;
	logic [CODE_BITS:0]   a_new, b_new, den_new, den_abs;
	logic                 den_zero;

	logic [NUM_W-1:0]     acc_q, term_ext, acc_next;
	logic [OHMS_BITS:0]   term;
	logic [CW-1:0]        cnt_q;

	logic [NUM_W-1:0]     num_fix;
	logic [NUM_W-2:0]     num_mag;
	logic [CODE_BITS:0]   num_high;
	logic                 nonpos, sat;

	logic [CODE_BITS-1:0] rem_q, rem_next;
	logic [OHMS_BITS-1:0] quo_q, quo_next;
	logic [CODE_BITS:0]   rem_sh, rem_diff;
	logic                 rem_ge;

	logic [OHMS_BITS-1:0] res_ohms_q;
	logic                 res_err_q;
	logic [OHMS_BITS-1:0] out_ohms_q;
	logic                 out_below_q, out_err_q, out_valid_q;

	// Each entry holds the code above the resistance.
	arl_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(point_index),
		.wdata({point_code, point_ohms}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign code_rd = ram_rdata[RAM_W-1:OHMS_BITS];
	assign ohms_rd = ram_rdata[OHMS_BITS-1:0];

	assign in_stall  = (state_q != arl_pkg::ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign conv_xfer = in_xfer && (action == arl_pkg::ACT_CONVERT);
	assign ram_we    = in_xfer && (action == arl_pkg::ACT_LOAD) &&
		((IDX_W + 1)'(point_index) < (IDX_W + 1)'(MAX_POINTS));
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		pts_ext = NW'(points_q);
		if (pts_ext < NW'(2)) begin
			n_clamp = CNT_W'(2);
		end else if (pts_ext > NW'(MAX_POINTS)) begin
			n_clamp = CNT_W'(MAX_POINTS);
		end else begin
			n_clamp = CNT_W'(pts_ext);
		end
	end

	always_comb begin
		unique case (state_q)
			arl_pkg::ST_SCAN:   ram_raddr = addr_q[IDX_W-1:0];
			arl_pkg::ST_FETCH0: ram_raddr = seg_q;
			arl_pkg::ST_FETCH1: ram_raddr = seg_q + IDX_W'(1);
			default:            ram_raddr = '0;
		endcase
	end

	// Table scan: one read issued per cycle, each response checked in the cycle after its read is issued.
	assign issue     = (state_q == arl_pkg::ST_SCAN) && (addr_q < n_q);
	assign last_rd   = (CNT_W'(idx_s1) == n_q - CNT_W'(1));
	assign hit       = (idx_s1 != '0) && (u_q > prev_q) && (u_q <= code_rd);
	assign found_any = found_q || hit;
	assign seg_any   = found_q ? seg_q : idx_s1 - IDX_W'(1);

	// Segment set-up from the two fetched points.
	always_comb begin
		a_new    = {1'b0, code_rd} - {1'b0, u_q};
		b_new    = {1'b0, u_q} - {1'b0, c0_q};
		den_new  = {1'b0, code_rd} - {1'b0, c0_q};
		den_abs  = den_new[CODE_BITS] ? (~den_new + 1'b1) : den_new;
		den_zero = (den_new == '0);
	end

	// Horner shift-add over the code differences, sign bit first:
	// num = r0 * (c1 - u) + r1 * (u - c0).
	always_comb begin
		term     = {1'b0, a_q[CODE_BITS] ? r0_q : '0} + {1'b0, b_q[CODE_BITS] ? r1_q : '0};
		term_ext = NUM_W'(term);
		if (cnt_q == CW'(CODE_BITS)) begin
			acc_next = ~term_ext + 1'b1;
		end else begin
			acc_next = {acc_q[NUM_W-2:0], 1'b0} + term_ext;
		end
	end

	always_comb begin
		num_fix  = den_neg_q ? (~acc_q + 1'b1) : acc_q;
		nonpos   = num_fix[NUM_W-1] || (num_fix == '0);
		num_mag  = num_fix[NUM_W-2:0];
		num_high = num_mag[NUM_W-2:OHMS_BITS];
		sat      = (num_high >= {1'b0, den_mag_q});
	end

	// Restoring divide; the saturation check leaves a remainder below the divisor.
	always_comb begin
		rem_sh   = {rem_q, quo_q[OHMS_BITS-1]};
		rem_diff = rem_sh - {1'b0, den_mag_q};
		rem_ge   = (rem_sh >= {1'b0, den_mag_q});
		rem_next = rem_ge ? rem_diff[CODE_BITS-1:0] : rem_sh[CODE_BITS-1:0];
		quo_next = {quo_q[OHMS_BITS-2:0], rem_ge};
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			arl_pkg::ST_IDLE: begin
				if (conv_xfer) begin
					state_next = arl_pkg::ST_SCAN;
				end
			end
			arl_pkg::ST_SCAN: begin
				if (rvalid_s1 && last_rd) begin
					if ((u_q > code_rd) || (u_q <= first_q) || found_any) begin
						state_next = arl_pkg::ST_FETCH0;
					end else begin
						state_next = arl_pkg::ST_DONE;
					end
				end
			end
			arl_pkg::ST_FETCH0: state_next = arl_pkg::ST_FETCH1;
			arl_pkg::ST_FETCH1: state_next = arl_pkg::ST_FETCH2;
			arl_pkg::ST_FETCH2: state_next = den_zero ? arl_pkg::ST_DONE : arl_pkg::ST_MUL;
			arl_pkg::ST_MUL: begin
				if (cnt_q == '0) begin
					state_next = arl_pkg::ST_NORM;
				end
			end
			arl_pkg::ST_NORM: state_next = (nonpos || sat) ? arl_pkg::ST_DONE : arl_pkg::ST_DIV;
			arl_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_next = arl_pkg::ST_DONE;
				end
			end
			arl_pkg::ST_DONE: begin
				if (out_free) begin
					state_next = arl_pkg::ST_IDLE;
				end
			end
			default: state_next = arl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= arl_pkg::ST_IDLE;
			points_q    <= arl_pkg::PTS_W'(2);
			limit_q     <= '0;
			rvalid_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_next;
			rvalid_s1 <= issue;
			if (cfg_we) begin
				unique case (cfg_index)
					arl_pkg::CFG_POINTS: points_q <= cfg_data[arl_pkg::PTS_W-1:0];
					arl_pkg::CFG_LIMIT:  limit_q  <= cfg_data[arl_pkg::LIMIT_W-1:0];
					default: ;
				endcase
			end
			if ((state_q == arl_pkg::ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q[IDX_W-1:0];
		unique case (state_q)
			arl_pkg::ST_IDLE: begin
				if (conv_xfer) begin
					u_q     <= sample_code;
					n_q     <= n_clamp;
					addr_q  <= '0;
					found_q <= 1'b0;
				end
			end
			arl_pkg::ST_SCAN: begin
				if (issue) begin
					addr_q <= addr_q + CNT_W'(1);
				end
				if (rvalid_s1) begin
					prev_q <= code_rd;
					if (idx_s1 == '0) begin
						first_q <= code_rd;
					end
					if (hit && !found_q) begin
						found_q <= 1'b1;
						seg_q   <= idx_s1 - IDX_W'(1);
					end
					if (last_rd) begin
						res_ohms_q <= '0;
						res_err_q  <= 1'b0;
						// Codes above the table win over codes below it, which win over a match.
						if (u_q > code_rd) begin
							seg_q <= IDX_W'(n_q - CNT_W'(2));
						end else if (u_q <= first_q) begin
							seg_q <= '0;
						end else begin
							seg_q <= seg_any;
						end
					end
				end
			end
			arl_pkg::ST_FETCH1: begin
				c0_q <= code_rd;
				r0_q <= ohms_rd;
			end
			arl_pkg::ST_FETCH2: begin
				a_q        <= a_new;
				b_q        <= b_new;
				r1_q       <= ohms_rd;
				den_neg_q  <= den_new[CODE_BITS];
				den_mag_q  <= den_abs[CODE_BITS-1:0];
				acc_q      <= '0;
				cnt_q      <= CW'(CODE_BITS);
				res_ohms_q <= '0;
				res_err_q  <= den_zero;
			end
			arl_pkg::ST_MUL: begin
				acc_q <= acc_next;
				a_q   <= {a_q[CODE_BITS-1:0], 1'b0};
				b_q   <= {b_q[CODE_BITS-1:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
			arl_pkg::ST_NORM: begin
				if (nonpos) begin
					res_ohms_q <= '0;
				end else if (sat) begin
					res_ohms_q <= '1;
				end else begin
					rem_q <= num_high[CODE_BITS-1:0];
					quo_q <= num_mag[OHMS_BITS-1:0];
					cnt_q <= CW'(OHMS_BITS - 1);
				end
			end
			arl_pkg::ST_DIV: begin
				rem_q      <= rem_next;
				quo_q      <= quo_next;
				res_ohms_q <= quo_next;
				cnt_q      <= cnt_q - CW'(1);
			end
			arl_pkg::ST_DONE: begin
				if (out_free) begin
					out_ohms_q  <= res_ohms_q;
					out_err_q   <= res_err_q;
					out_below_q <= !res_err_q && (CMP_W'(res_ohms_q) < CMP_W'(limit_q));
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign ohms          = out_ohms_q;
	assign below_limit   = out_below_q;
	assign segment_error = out_err_q;

`ifndef SYNTH
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && segment_error) |-> ((ohms == '0) && !below_limit))
		else $error("segment error with nonzero result fields");

	a_mul_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arl_pkg::ST_MUL) |-> (den_mag_q != '0))
		else $error("multiply started on a zero-width segment");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arl_pkg::ST_DIV) |-> (rem_q < den_mag_q))
		else $error("divider remainder not below divisor");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == arl_pkg::ST_SCAN) && rvalid_s1) |-> (CNT_W'(idx_s1) < n_q))
		else $error("table scan read beyond points in use");
`endif

endmodule

// File: tb/adc_to_resistance_linearizer_test.sv
// Self-checking regression for the ADC code to resistance linearizer.
module adc_to_resistance_linearizer_test;

	localparam int NPTS = 16;
	localparam int CODE_W = 16;
	localparam int OHM_W = 32;
	localparam int ITEM_TARGET = 1450;
	localparam int QUIET_AFTER = 1300;
	localparam int SETTLE_CYCLES = 100;
	localparam longint OHM_MAX = 64'h0000_0000_FFFF_FFFF;

	typedef struct {
		logic [OHM_W-1:0] ohms;
		logic             below;
		logic             seg_err;
	} reading_t;

	// Shadow of the calibration table and registers, plus the readings still owed by the block.
	class linearizer_board;
		logic [CODE_W-1:0]           cal_code [NPTS];
		logic [OHM_W-1:0]            cal_res [NPTS];
		logic [arl_pkg::PTS_W-1:0]   points;
		logic [arl_pkg::LIMIT_W-1:0] limit;
		reading_t                    expected_readings [$];
		int                          mismatches;

		function new();
			points = 5'd2;
			limit = '0;
			mismatches = 0;
			foreach (cal_code[i]) begin
				cal_code[i] = '0;
				cal_res[i] = '0;
			end
		endfunction

		function void configure(logic [arl_pkg::CFG_IDX_W-1:0] idx,
				logic [arl_pkg::CFG_DATA_W-1:0] data);
			if (idx == arl_pkg::CFG_POINTS) begin
				points = data[arl_pkg::PTS_W-1:0];
			end else begin
				limit = data[arl_pkg::LIMIT_W-1:0];
			end
		endfunction

		function reading_t convert_sample(logic [CODE_W-1:0] u);
			int n;
			int j;
			int seg;
			bit found;
			longint c0, c1, r0, r1, x, den, num;
			reading_t r;
			n = int'(points);
			if (n < 2) n = 2;
			if (n > NPTS) n = NPTS;
			seg = 0;
			found = 1'b0;
			for (j = 0; j + 1 < n; j++) begin
				if (!found && u > cal_code[j] && u <= cal_code[j+1]) begin
					seg = j;
					found = 1'b1;
				end
			end
			if (u <= cal_code[0]) begin
				seg = 0;
				found = 1'b1;
			end
			if (u > cal_code[n-1]) begin
				seg = n - 2;
				found = 1'b1;
			end
			r.ohms = '0;
			r.seg_err = 1'b0;
			if (found) begin
				c0 = longint'(cal_code[seg]);
				c1 = longint'(cal_code[seg+1]);
				r0 = longint'(cal_res[seg]);
				r1 = longint'(cal_res[seg+1]);
				x = longint'(u);
				den = c1 - c0;
				if (den == 0) begin
					r.seg_err = 1'b1;
				end else begin
					num = r0 * (c1 - x) + r1 * (x - c0);
					// A descending segment divides by its magnitude with the sign moved to the numerator.
					if (den < 0) begin
						den = -den;
						num = -num;
					end
					if (num > 0) begin
						r.ohms = (num / den > OHM_MAX) ? OHM_MAX[OHM_W-1:0] : OHM_W'(num / den);
					end
				end
			end
			r.below = !r.seg_err && (r.ohms < limit);
			return r;
		endfunction

		function void take_item(logic act, logic [3:0] idx, logic [CODE_W-1:0] pc,
				logic [OHM_W-1:0] po, logic [CODE_W-1:0] sc);
			if (act == arl_pkg::ACT_LOAD) begin
				cal_code[idx] = pc;
				cal_res[idx] = po;
			end else begin
				expected_readings.push_back(convert_sample(sc));
			end
		endfunction

		function void check_reading(logic [OHM_W-1:0] got_ohms, logic got_below, logic got_err);
			reading_t want;
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: ohms=%0d below_limit=%0b segment_error=%0b",
						got_ohms, got_below, got_err);
				return;
			end
			want = expected_readings.pop_front();
			if (got_ohms !== want.ohms || got_below !== want.below || got_err !== want.seg_err) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected ohms=%0d below_limit=%0b segment_error=%0b,",
						want.ohms, want.below, want.seg_err,
						" got ohms=%0d below_limit=%0b segment_error=%0b",
						got_ohms, got_below, got_err);
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [arl_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [arl_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic                           action;
	logic [3:0]                     point_index;
	logic [CODE_W-1:0]              point_code;
	logic [OHM_W-1:0]               point_ohms;
	logic [CODE_W-1:0]              sample_code;
	logic                           out_valid;
	logic                           out_stall;
	logic [OHM_W-1:0]               ohms;
	logic                           below_limit;
	logic                           segment_error;

	bit              quiet;
	int              items_sent;
	linearizer_board board;

	adc_to_resistance_linearizer #(
		.MAX_POINTS(NPTS),
		.CODE_BITS(CODE_W),
		.OHMS_BITS(OHM_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.point_index(point_index),
		.point_code(point_code),
		.point_ohms(point_ohms),
		.sample_code(sample_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ohms(ohms),
		.below_limit(below_limit),
		.segment_error(segment_error)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(logic act, logic [3:0] idx, logic [CODE_W-1:0] pc,
			logic [OHM_W-1:0] po, logic [CODE_W-1:0] sc);
		int gap;
		quiet = (items_sent >= QUIET_AFTER);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		point_index <= idx;
		point_code <= pc;
		point_ohms <= po;
		sample_code <= sc;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.take_item(act, idx, pc, po, sc);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic load_point(logic [3:0] idx, logic [CODE_W-1:0] code, logic [OHM_W-1:0] res);
		send_item(arl_pkg::ACT_LOAD, idx, code, res, CODE_W'($urandom));
	endtask

	task automatic convert(logic [CODE_W-1:0] code);
		send_item(arl_pkg::ACT_CONVERT, 4'($urandom), CODE_W'($urandom), $urandom, code);
	endtask

	// Loads leave no result behind, so the block gets extra time to go idle.
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (board.expected_readings.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [arl_pkg::CFG_IDX_W-1:0] idx,
			logic [arl_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		board.configure(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_reading(ohms, below_limit, segment_error);
	end

	initial begin
		int burst;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 18);
				out_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#8000000;
		$display("adc_to_resistance_linearizer regression: fail");
		$finish;
	end

	initial begin
		int n, neff, k, a, b, m, mode, step_max, code_i, j;
		longint res;
		logic [CODE_W-1:0] tc [NPTS];
		logic [OHM_W-1:0] tr [NPTS];
		logic [CODE_W-1:0] tmp;
		logic [CODE_W-1:0] u;
		logic [arl_pkg::CFG_DATA_W-1:0] lim;

		board = new();
		quiet = 1'b0;
		items_sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = arl_pkg::ACT_LOAD;
		point_index = '0;
		point_code = '0;
		point_ohms = '0;
		sample_code = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every entry is written before the first conversion so no scan touches an unwritten one.
		for (k = 0; k < NPTS; k++)
			load_point(4'(k), CODE_W'(100 + 4000 * k),
				(k == NPTS - 1) ? 32'hFFFF_FFFF : OHM_W'(longint'(k) * 250_000_000));
		convert(16'd0);

		settle();
		write_reg(arl_pkg::CFG_POINTS, 32'd16);
		write_reg(arl_pkg::CFG_LIMIT, 32'd2_000_000_000);
		convert(16'hFFFF);
		convert(16'd30000);

		settle();
		write_reg(arl_pkg::CFG_POINTS, 32'd2);
		write_reg(arl_pkg::CFG_LIMIT, 32'hFFFF_FFFF);
		// Extrapolating past a falling segment goes negative and clamps to zero.
		load_point(4'd0, 16'd1000, 32'd1_000_000);
		load_point(4'd1, 16'd2000, 32'd0);
		convert(16'd3000);
		load_point(4'd0, 16'd3000, 32'd7000);
		convert(16'd2000);
		load_point(4'd1, 16'd3000, 32'd5);
		convert(16'd3000);
		load_point(4'd0, 16'd0, 32'd0);
		load_point(4'd1, 16'hFFFF, 32'hFFFF_FFFF);
		convert(16'hFFFF);
		convert(16'h8000);

		while (items_sent < ITEM_TARGET) begin
			settle();
			k = $urandom_range(0, 19);
			if (k < 12)
				n = $urandom_range(2, 5);
			else if (k < 17)
				n = $urandom_range(6, 16);
			else if ($urandom_range(0, 1) == 0)
				n = $urandom_range(0, 1);
			else
				n = $urandom_range(17, 31);
			write_reg(arl_pkg::CFG_POINTS,
				{($urandom_range(0, 3) == 0) ? 27'($urandom) : 27'd0, 5'(n)});
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 3))
					0: lim = '0;
					1: lim = '1;
					2: lim = $urandom;
					default: lim = $urandom_range(0, 50_000_000);
				endcase
				write_reg(arl_pkg::CFG_LIMIT, lim);
			end
			neff = (n < 2) ? 2 : (n > NPTS) ? NPTS : n;

			// Most phases start from a fresh ascending table; some get a swapped pair.
			if ($urandom_range(0, 3) != 0) begin
				code_i = $urandom_range(0, 30000);
				step_max = (65535 - code_i) / (neff - 1);
				mode = $urandom_range(0, 2);
				res = (mode == 1) ? longint'($urandom) : longint'($urandom_range(0, 100000));
				for (k = 0; k < neff; k++) begin
					tc[k] = CODE_W'(code_i);
					tr[k] = OHM_W'(res);
					if ($urandom_range(0, 7) != 0)
						code_i = code_i + int'($urandom_range(1, step_max));
					case (mode)
						0: begin
							res = res + longint'($urandom_range(0, 200_000_000));
							if (res > OHM_MAX) res = OHM_MAX;
						end
						1: begin
							res = res - longint'($urandom_range(0, 200_000_000));
							if (res < 0) res = 0;
						end
						default: res = longint'($urandom);
					endcase
				end
				if ($urandom_range(0, 7) == 0) begin
					a = $urandom_range(0, neff - 1);
					b = $urandom_range(0, neff - 1);
					tmp = tc[a];
					tc[a] = tc[b];
					tc[b] = tmp;
				end
				for (k = 0; k < neff; k++)
					load_point(4'(k), tc[k], tr[k]);
			end

			m = $urandom_range(10, 30);
			repeat (m) begin
				if ($urandom_range(0, 6) == 0) begin
					load_point(4'($urandom), CODE_W'($urandom), $urandom);
				end else begin
					j = $urandom_range(0, neff - 1);
					case ($urandom_range(0, 5))
						0: u = CODE_W'($urandom);
						1: u = board.cal_code[j];
						2: u = (board.cal_code[j] == '1) ? '1 : board.cal_code[j] + 1'b1;
						3: u = (board.cal_code[j] == '0) ? '0 : board.cal_code[j] - 1'b1;
						4: u = CODE_W'($urandom_range(0, board.cal_code[0]));
						default: u = CODE_W'($urandom_range(board.cal_code[neff-1], 16'hFFFF));
					endcase
					convert(u);
				end
			end
		end

		settle();
		if (board.mismatches == 0 && board.expected_readings.size() == 0) begin
			$display("adc_to_resistance_linearizer regression: pass");
		end else begin
			$display("adc_to_resistance_linearizer regression: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/arl_pkg.sv
design/arl_ram.sv
design/adc_to_resistance_linearizer.sv
tb/adc_to_resistance_linearizer_test.sv
